### sv/plid_pkg.sv
// Shared constants, codes and types of the positional list.
`timescale 1ns / 1ps
`default_nettype none
package plid_pkg;

	localparam int CAPACITY = 16;
	localparam int POS_W    = 5;
	localparam int VAL_W    = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_DELETE = 2'd1,
		REQ_GET    = 2'd2
	} req_e_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2
	} status_e_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		logic load_req;
		logic exec;
	} dp_cmd_t;

endpackage
`default_nettype wire

### sv/plid_ctrl.sv
// Controller state machine of the positional list: handshakes and sequencing.
`timescale 1ns / 1ps
`default_nettype none
module plid_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output plid_pkg::dp_cmd_t      cmd
);

	plid_pkg::state_t state_q, state_nxt;
	logic             rsp_valid_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			plid_pkg::S_IDLE: begin
				if (req_valid && req_ready) state_nxt = plid_pkg::S_EXEC;
			end
			plid_pkg::S_EXEC: begin
				state_nxt = plid_pkg::S_IDLE;
			end
			default: begin
				state_nxt = plid_pkg::S_IDLE;
			end
		endcase
	end

	// A new word is taken only when the response register is empty or drains
	// at the same edge, so the execute cycle always finds it free.
	always_comb begin
		req_ready    = 1'b0;
		cmd.load_req = 1'b0;
		cmd.exec     = 1'b0;
		case (state_q)
			plid_pkg::S_IDLE: begin
				req_ready    = !rsp_valid_q || rsp_ready;
				cmd.load_req = req_valid && (!rsp_valid_q || rsp_ready);
			end
			plid_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= plid_pkg::S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == plid_pkg::S_EXEC) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule
`default_nettype wire

### sv/plid_dp.sv
// Datapath of the positional list: entry cells, count and response registers.
`timescale 1ns / 1ps
`default_nettype none
module plid_dp (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire plid_pkg::dp_cmd_t                      cmd,
	input  wire logic [1:0]                             req_type,
	input  wire logic [plid_pkg::POS_W-1:0]             position,
	input  wire logic signed [plid_pkg::VAL_W-1:0]      value,
	output logic [1:0]                                  status,
	output logic signed [plid_pkg::VAL_W-1:0]           read_value,
	output logic [plid_pkg::POS_W-1:0]                  count
);

	logic [1:0]                      type_q;
	logic [plid_pkg::CMP_W-1:0]      pos_q;
	logic [plid_pkg::VAL_W-1:0]      val_q;
	logic [plid_pkg::VAL_W-1:0]      cell_q [plid_pkg::CAPACITY];
	logic [plid_pkg::VAL_W-1:0]      up_src [plid_pkg::CAPACITY];
	logic [plid_pkg::VAL_W-1:0]      dn_src [plid_pkg::CAPACITY];
	logic [plid_pkg::CNT_W-1:0]      count_q;
	logic [1:0]                      status_q;
	logic [plid_pkg::VAL_W-1:0]      rdata_q;

	logic [plid_pkg::CMP_W-1:0]      cnt_ext;
	logic [plid_pkg::IDX_W-1:0]      idx;
	logic                            do_ins;
	logic                            do_del;
	logic                            do_get;
	plid_pkg::status_e_t             nstatus;

	// Request register.
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			type_q <= req_type;
			pos_q  <= plid_pkg::CMP_W'(position);
			val_q  <= value;
		end
	end

	assign cnt_ext = plid_pkg::CMP_W'(count_q);
	assign idx     = pos_q[plid_pkg::IDX_W-1:0];

	always_comb begin
		do_ins  = 1'b0;
		do_del  = 1'b0;
		do_get  = 1'b0;
		nstatus = plid_pkg::ST_BADPOS;
		case (type_q)
			plid_pkg::REQ_INSERT: begin
				if (pos_q > cnt_ext) begin
					nstatus = plid_pkg::ST_BADPOS;
				end else if (count_q == plid_pkg::CNT_W'(plid_pkg::CAPACITY)) begin
					nstatus = plid_pkg::ST_FULL;
				end else begin
					do_ins  = 1'b1;
					nstatus = plid_pkg::ST_OK;
				end
			end
			plid_pkg::REQ_DELETE: begin
				if (pos_q < cnt_ext) begin
					do_del  = 1'b1;
					nstatus = plid_pkg::ST_OK;
				end
			end
			plid_pkg::REQ_GET: begin
				if (pos_q < cnt_ext) begin
					do_get  = 1'b1;
					nstatus = plid_pkg::ST_OK;
				end
			end
			default: begin
				nstatus = plid_pkg::ST_BADPOS;
			end
		endcase
	end

	// Every cell compares its own index with the position and either takes
	// the new word, its lower neighbor, its upper neighbor, or holds.
	for (genvar g = 0; g < plid_pkg::CAPACITY; g++) begin : g_cell
		if (g == 0) begin : g_first
			assign up_src[g] = val_q;
		end else begin : g_up
			assign up_src[g] = cell_q[g-1];
		end
		if (g == plid_pkg::CAPACITY - 1) begin : g_last
			assign dn_src[g] = cell_q[g];
		end else begin : g_dn
			assign dn_src[g] = cell_q[g+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.exec) begin
				if (do_ins) begin
					if (plid_pkg::CMP_W'(g) == pos_q) begin
						cell_q[g] <= val_q;
					end else if (plid_pkg::CMP_W'(g) > pos_q) begin
						cell_q[g] <= up_src[g];
					end
				end else if (do_del) begin
					if (plid_pkg::CMP_W'(g) >= pos_q) begin
						cell_q[g] <= dn_src[g];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			if (do_ins) begin
				count_q <= count_q + plid_pkg::CNT_W'(1);
			end else if (do_del) begin
				count_q <= count_q - plid_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= nstatus;
			rdata_q  <= do_get ? cell_q[idx] : '0;
		end
	end

	assign status     = status_q;
	assign read_value = rdata_q;
	assign count      = plid_pkg::POS_W'(count_q);

endmodule
`default_nettype wire

### sv/positional_list_insert_delete.sv
// The response registers are loaded from the request register in the EXEC state.
// The accept/execute controller takes no new request while it is in its EXEC state.
// A new request is taken while the previous response is being taken in the same cycle.
// Reset clears the entry count and all handshake state; entry cells are not reset
// and stay unread until written by an insert.
`timescale 1ns / 1ps
`default_nettype none
module positional_list_insert_delete (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               req_valid,
	output logic                                    req_ready,
	input  wire logic [1:0]                         req_type,
	input  wire logic [plid_pkg::POS_W-1:0]         position,
	input  wire logic signed [plid_pkg::VAL_W-1:0]  value,
	output logic                                    rsp_valid,
	input  wire logic                               rsp_ready,
	output logic [1:0]                              status,
	output logic signed [plid_pkg::VAL_W-1:0]       read_value,
	output logic [plid_pkg::POS_W-1:0]              count
);

	plid_pkg::dp_cmd_t cmd;

	plid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	plid_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.req_type   (req_type),
		.position   (position),
		.value      (value),
		.status     (status),
		.read_value (read_value),
		.count      (count)
	);

	a_rsp_follows_req: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
		else $error("response appeared without a request two cycles earlier");

	a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |-> !req_ready)
		else $error("request accepted while a response is stalled");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (count <= plid_pkg::POS_W'(plid_pkg::CAPACITY)))
		else $error("entry count exceeds capacity");

	a_fail_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (status != plid_pkg::ST_OK)) |-> (read_value == '0))
		else $error("failed request returned nonzero read word");

endmodule
`default_nettype wire
